// ===== sv/mm2d_pkg.sv =====
// Shared types, constants and arithmetic helpers for the mipmap level placement core.
package mm2d_pkg;

    localparam int MAX_LEVELS = 15;
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 104;

    localparam logic [3:0]  LAST_LEVEL_MAX = 4'(MAX_LEVELS - 1);
    localparam logic [14:0] X_MAX = 15'h7FFF;
    localparam logic [26:0] Y_MAX = 27'h7FF_FFFF;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ALIGN_W = 3'd0;
    localparam logic [2:0] CFG_ALIGN_H = 3'd1;
    localparam logic [2:0] CFG_BLOCK_W = 3'd2;
    localparam logic [2:0] CFG_BLOCK_H = 3'd3;
    localparam logic [2:0] CFG_SLICES  = 3'd4;
    localparam logic [2:0] CFG_MINIFY  = 3'd5;

    typedef struct packed {
        logic [3:0] align_w_log2;
        logic [3:0] align_h_log2;
        logic [2:0] block_w_log2;
        logic [2:0] block_h_log2;
        logic       slices_at_each_lod;
        logic       minify_depth;
    } cfg_t;

    // One classified surface, handed from the front end to the back end.
    typedef struct packed {
        logic [14:0] width;
        logic [14:0] height;
        logic [11:0] depth;
        logic [3:0]  lod_lo;
        logic [3:0]  lod_hi;
        logic        range_error;
        logic [14:0] span_w;
    } job_t;

    typedef struct packed {
        logic [3:0]  level;
        logic [14:0] x_offset;
        logic [26:0] y_offset;
        logic [11:0] level_depth;
        logic [14:0] span_w;
        logic [26:0] span_h;
        logic        last;
        logic        range_error;
    } res_t;

    function automatic logic [16:0] round_up(input logic [16:0] v, input logic [3:0] lg);
        logic [16:0] m;
        m = (17'(1) << lg) - 17'(1);
        return (v + m) & ~m;
    endfunction

    function automatic logic [14:0] halve_w(input logic [14:0] v);
        return (v[14:1] == 14'd0) ? 15'd1 : {1'b0, v[14:1]};
    endfunction

    function automatic logic [11:0] halve_d(input logic [11:0] v);
        return (v[11:1] == 11'd0) ? 12'd1 : {1'b0, v[11:1]};
    endfunction

    // Rows one level occupies: aligned height in blocks, times slices if requested.
    function automatic logic [28:0] img_rows(input logic [14:0] h, input logic [11:0] d,
                                             input cfg_t cfg);
        logic [16:0] a;
        logic [16:0] s;
        a = round_up({2'b00, h}, cfg.align_h_log2);
        s = a >> cfg.block_h_log2;
        return cfg.slices_at_each_lod ? 29'(s) * 29'(d) : 29'(s);
    endfunction

    function automatic logic [14:0] sat_x(input logic [16:0] v);
        return (v > 17'(X_MAX)) ? X_MAX : v[14:0];
    endfunction

    function automatic logic [26:0] sat_y(input logic [31:0] v);
        return (v > 32'(Y_MAX)) ? Y_MAX : v[26:0];
    endfunction

endpackage

// ===== sv/mm2d_front.sv =====
// Front end: unpacks an incoming surface, checks its level range and sizes the layout width.
module mm2d_front (
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mm2d_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  mm2d_pkg::cfg_t                       cfg,
    input  logic                                 q_full,
    output logic                                 q_push,
    output mm2d_pkg::job_t                       q_job
);

    logic [14:0] w0;
    logic [3:0]  first_l;
    logic [3:0]  last_raw;
    logic [3:0]  last_c;
    logic [14:0] hw;
    logic [14:0] hhw;
    logic [16:0] tw_base;
    logic [17:0] m1;
    logic [17:0] tw_wide;

    assign w0       = s_tdata[14:0];
    assign first_l  = s_tdata[45:42];
    assign last_raw = s_tdata[49:46];

    assign last_c = (last_raw > mm2d_pkg::LAST_LEVEL_MAX) ? mm2d_pkg::LAST_LEVEL_MAX : last_raw;

    assign hw      = mm2d_pkg::halve_w(w0);
    assign hhw     = mm2d_pkg::halve_w(hw);
    assign tw_base = mm2d_pkg::round_up({2'b00, w0}, {1'b0, cfg.block_w_log2});
    assign m1      = 18'(mm2d_pkg::round_up({2'b00, hw}, cfg.align_w_log2))
                   + 18'(mm2d_pkg::round_up({2'b00, hhw}, {1'b0, cfg.block_w_log2}));

    // With more than one level, the second and third levels must fit side by side.
    assign tw_wide = ((first_l != last_c) && (m1 > 18'(tw_base))) ? m1 : 18'(tw_base);

    always_comb begin
        q_job.width       = w0;
        q_job.height      = s_tdata[29:15];
        q_job.depth       = s_tdata[41:30];
        q_job.lod_lo      = first_l;
        q_job.lod_hi      = last_c;
        q_job.range_error = (first_l > last_c);
        q_job.span_w      = (tw_wide > 18'(mm2d_pkg::X_MAX)) ? mm2d_pkg::X_MAX : tw_wide[14:0];
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// ===== sv/mm2d_queue.sv =====
// Short job queue between the front end and the back end.
module mm2d_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mm2d_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output mm2d_pkg::job_t head
);

    mm2d_pkg::job_t entries_reg [mm2d_pkg::Q_DEPTH];

    logic [mm2d_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mm2d_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mm2d_pkg::QPTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (mm2d_pkg::QPTR_W + 1)'(mm2d_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == mm2d_pkg::QPTR_W'(mm2d_pkg::Q_DEPTH - 1))
                        ? '0 : wr_ptr_reg + mm2d_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == mm2d_pkg::QPTR_W'(mm2d_pkg::Q_DEPTH - 1))
                        ? '0 : rd_ptr_reg + mm2d_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (mm2d_pkg::QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (mm2d_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/mm2d_back.sv =====
// Back end: walks a job's levels into an output register, one per cycle unless stalled.
module mm2d_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  mm2d_pkg::cfg_t cfg,
    input  logic           q_empty,
    input  mm2d_pkg::job_t q_head,
    output logic           q_pop,
    input  logic           m_tready,
    output logic           m_tvalid,
    output mm2d_pkg::res_t res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    logic [14:0] w_reg;
    logic [14:0] h_reg;
    logic [11:0] d_reg;
    logic [3:0]  lv_reg;
    logic [3:0]  last_reg;
    logic [3:0]  idx_reg;
    logic        err_reg;
    logic [14:0] tw_reg;
    logic [15:0] x_reg;
    logic [31:0] y_reg;
    logic [31:0] th_reg;
    logic [28:0] img_reg;

    mm2d_pkg::res_t res_reg;

    logic        out_free;
    logic        emit;
    logic        final_level;
    logic [14:0] h_half;
    logic [11:0] d_step;
    logic [14:0] img_h;
    logic [11:0] img_d;
    logic [28:0] img_calc;
    logic [31:0] bottom;
    logic [31:0] th_new;

    assign out_free    = !m_valid_reg || m_tready;
    assign emit        = (state_reg == ST_RUN) && out_free;
    assign final_level = err_reg || (lv_reg == last_reg);
    assign q_pop       = (state_reg == ST_IDLE) && !q_empty;

    assign h_half = mm2d_pkg::halve_w(h_reg);
    assign d_step = cfg.minify_depth ? mm2d_pkg::halve_d(d_reg) : d_reg;

    // The row count is computed one level ahead so the accumulate step sees a register.
    assign img_h    = (state_reg == ST_IDLE) ? q_head.height : h_half;
    assign img_d    = (state_reg == ST_IDLE) ? q_head.depth : d_step;
    assign img_calc = mm2d_pkg::img_rows(img_h, img_d, cfg);

    assign bottom = y_reg + 32'(img_reg);
    assign th_new = (bottom > th_reg) ? bottom : th_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free && final_level) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            w_reg    <= q_head.width;
            h_reg    <= q_head.height;
            d_reg    <= q_head.depth;
            lv_reg   <= q_head.lod_lo;
            last_reg <= q_head.lod_hi;
            err_reg  <= q_head.range_error;
            tw_reg   <= q_head.span_w;
            idx_reg  <= 4'd0;
            x_reg    <= 16'd0;
            y_reg    <= 32'd0;
            th_reg   <= 32'd0;
            img_reg  <= img_calc;
        end else if (emit && !final_level) begin
            w_reg   <= mm2d_pkg::halve_w(w_reg);
            h_reg   <= h_half;
            d_reg   <= d_step;
            lv_reg  <= lv_reg + 4'd1;
            idx_reg <= idx_reg + 4'd1;
            th_reg  <= th_new;
            img_reg <= img_calc;
            // The level after the second steps right; every other level stacks downward.
            if (idx_reg == 4'd1) begin
                x_reg <= x_reg + 16'(mm2d_pkg::round_up({2'b00, w_reg}, cfg.align_w_log2));
            end else begin
                y_reg <= bottom;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            res_reg.level <= lv_reg;
            if (err_reg) begin
                res_reg.x_offset    <= '0;
                res_reg.y_offset    <= '0;
                res_reg.level_depth <= '0;
                res_reg.span_w      <= '0;
                res_reg.span_h      <= '0;
                res_reg.last        <= 1'b1;
                res_reg.range_error <= 1'b1;
            end else begin
                res_reg.x_offset    <= mm2d_pkg::sat_x({1'b0, x_reg});
                res_reg.y_offset    <= mm2d_pkg::sat_y(y_reg);
                res_reg.level_depth <= d_reg;
                res_reg.span_w      <= tw_reg;
                res_reg.span_h      <= mm2d_pkg::sat_y(th_new);
                res_reg.last        <= (lv_reg == last_reg);
                res_reg.range_error <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign res      = res_reg;

endmodule

// ===== sv/mipmap_2d_level_placement_core.sv =====
// Top level of the mipmap level placement core: configuration registers and stream ports.
//
// For each surface taken on the input stream the core emits one result per mip level
// from the first requested level to the clamped last one, in level order, with tlast on
// the final one; a reversed range yields a single result flagged in tuser. The front end
// sizes the layout width and queues the surface in a two-entry queue, so it takes new
// surfaces while the back end works. The back end loads a surface in its idle state
// and then emits one level per cycle when the output is not stalled; that stepping
// sets the sustained rate. Configuration writes are taken at any time, one per cycle,
// and are meant to happen only while the core is idle.
module mipmap_2d_level_placement_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [2:0]                           cfg_index,
    input  logic [7:0]                           cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // base_width, base_height, base_depth, lowest level, highest level, zero pad
    input  logic [mm2d_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // level, x_offset, y_offset, level_depth, layout width, layout height, zero pad
    output logic [mm2d_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,
    // range_error
    output logic                                 m_tuser
);

    mm2d_pkg::cfg_t cfg_reg;
    mm2d_pkg::job_t front_job;
    mm2d_pkg::job_t q_head;
    mm2d_pkg::res_t res;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.align_w_log2       <= 4'd2;
            cfg_reg.align_h_log2       <= 4'd1;
            cfg_reg.block_w_log2       <= 3'd0;
            cfg_reg.block_h_log2       <= 3'd0;
            cfg_reg.slices_at_each_lod <= 1'b0;
            cfg_reg.minify_depth       <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mm2d_pkg::CFG_ALIGN_W: cfg_reg.align_w_log2       <= cfg_data[3:0];
                mm2d_pkg::CFG_ALIGN_H: cfg_reg.align_h_log2       <= cfg_data[3:0];
                mm2d_pkg::CFG_BLOCK_W: cfg_reg.block_w_log2       <= cfg_data[2:0];
                mm2d_pkg::CFG_BLOCK_H: cfg_reg.block_h_log2       <= cfg_data[2:0];
                mm2d_pkg::CFG_SLICES:  cfg_reg.slices_at_each_lod <= cfg_data[0];
                mm2d_pkg::CFG_MINIFY:  cfg_reg.minify_depth       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mm2d_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (front_job)
    );

    mm2d_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    mm2d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res      (res)
    );

    assign m_tdata = {4'b0000, res.span_h, res.span_w, res.level_depth,
                      res.y_offset, res.x_offset, res.level};
    assign m_tlast = res.last;
    assign m_tuser = res.range_error;

`ifndef NO_ASSERTIONS
    // An error result stands alone, so it must also close the surface.
    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("range error result without tlast");

    a_err_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (res.x_offset == '0) && (res.y_offset == '0)
                                && (res.span_w == '0) && (res.span_h == '0))
        else $error("range error result carries placement data");

    // The running height always covers the top edge of the level being reported.
    a_height_covers_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> res.y_offset <= res.span_h)
        else $error("total height below level offset");
`endif

endmodule
